/* src/ssts_pkg.sv */
// ----------------------------------------------------------------------------
// ssts_pkg: shared types and constants for the sorted set table
// Table size, field widths, request and result codes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssts_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic [1:0]                    kind_t;
  typedef logic [2:0]                    code_t;
  typedef logic signed [VALUE_BITS-1:0]  value_t;

  // request kinds
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_DELETE = 2'd1;
  localparam kind_t KIND_SEARCH = 2'd2;
  localparam kind_t KIND_LIST   = 2'd3;

  // result codes
  localparam code_t CODE_INSERTED = 3'd0;
  localparam code_t CODE_PRESENT_ALREADY = 3'd1;
  localparam code_t CODE_FULL     = 3'd2;
  localparam code_t CODE_DELETED  = 3'd3;
  localparam code_t CODE_ABSENT   = 3'd4;
  localparam code_t CODE_PRESENT  = 3'd5;
  localparam code_t CODE_LISTED   = 3'd6;
  localparam code_t CODE_EMPTY    = 3'd7;

  // source of the result's value field
  typedef enum logic [1:0] {
    SEL_REQ,
    SEL_CELL,
    SEL_ZERO
  } item_sel_t;

  typedef struct packed {
    logic             ins;       // shift in request value
    logic             del;       // close the gap at the match
    logic             load;      // capture a result into the output stage
    code_t            code;
    logic             last;
    item_sel_t        item_sel;
    logic [IDX_W-1:0] rd_idx;    // cell read by list
  } dp_cmd_t;

  typedef struct packed {
    logic             found;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
  } dp_stat_t;

endpackage

/* src/ssts_datapath.sv */
// ----------------------------------------------------------------------------
// ssts_datapath: row of sorted value cells and the result register
// Every cell compares against the request value in parallel; insert and
// delete shift the cells above the insertion point by one place.
// ----------------------------------------------------------------------------
module ssts_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  ssts_pkg::value_t  in_value,
  input  ssts_pkg::dp_cmd_t cmd,
  output ssts_pkg::dp_stat_t stat,
  output ssts_pkg::code_t   out_code,
  output ssts_pkg::value_t  out_item_value,
  output logic              out_last
);
  import ssts_pkg::*;

  value_t           cell_r   [CAPACITY];
  value_t           cell_nxt [CAPACITY];
  value_t           prev_val [CAPACITY];   // value of the cell below (request at 0)
  value_t           next_val [CAPACITY];   // value of the cell above
  logic [CAPACITY-1:0] lt;                 // occupied and below the request
  logic [CAPACITY-1:0] eq;                 // occupied and equal to the request
  logic [CAPACITY-1:0] lt_prev;
  logic [CNT_W-1:0] count_r, count_nxt;
  code_t            code_r;
  value_t           item_r, item_nxt;
  logic             last_r;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < count_r) && (cell_r[i] < in_value);
      eq[i] = (CNT_W'(i) < count_r) && (cell_r[i] == in_value);
    end
    prev_val[0] = in_value;
    lt_prev[0]  = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      prev_val[i] = cell_r[i-1];
      lt_prev[i]  = lt[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      next_val[i] = cell_r[i+1];
    end
    next_val[CAPACITY-1] = cell_r[CAPACITY-1];
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.ins && !lt[i]) begin
        cell_nxt[i] = lt_prev[i] ? in_value : prev_val[i];
      end else if (cmd.del && !lt[i]) begin
        cell_nxt[i] = next_val[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd.item_sel)
      SEL_REQ:  item_nxt = in_value;
      SEL_CELL: item_nxt = cell_r[cmd.rd_idx];
      default:  item_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    if (cmd.load) begin
      code_r <= cmd.code;
      item_r <= item_nxt;
      last_r <= cmd.last;
    end
  end

  assign stat.found = |eq;
  assign stat.full  = (count_r == CNT_W'(CAPACITY));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  assign out_code       = code_r;
  assign out_item_value = item_r;
  assign out_last       = last_r;

endmodule

/* src/ssts_ctrl.sv */
// ----------------------------------------------------------------------------
// ssts_ctrl: request controller
// Decodes each request against the table status, issues the update and result
// commands, and for a list walks the cells one per cycle while not stalled.
// ----------------------------------------------------------------------------
module ssts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  ssts_pkg::kind_t    in_kind,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ssts_pkg::dp_stat_t stat,
  output ssts_pkg::dp_cmd_t  cmd
);
  import ssts_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic             state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             accept;
  logic             list_last;

  assign out_free  = !out_valid_r || !out_stall;
  assign accept    = (state_r == S_IDLE) && in_valid && out_free;
  assign list_last = (CNT_W'(idx_r) + CNT_W'(1)) == stat.count;

  always_comb begin
    cmd       = '0;
    cmd.item_sel = SEL_REQ;
    cmd.rd_idx   = idx_r;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          cmd.last = 1'b1;
          unique case (in_kind)
            KIND_INSERT: begin
              if (stat.found) begin
                cmd.code = CODE_PRESENT_ALREADY;
              end else if (stat.full) begin
                cmd.code = CODE_FULL;
              end else begin
                cmd.code = CODE_INSERTED;
                cmd.ins  = 1'b1;
              end
            end
            KIND_DELETE: begin
              if (stat.found) begin
                cmd.code = CODE_DELETED;
                cmd.del  = 1'b1;
              end else begin
                cmd.code = CODE_ABSENT;
              end
            end
            KIND_SEARCH: begin
              cmd.code = stat.found ? CODE_PRESENT : CODE_ABSENT;
            end
            default: begin
              if (stat.empty) begin
                cmd.code     = CODE_EMPTY;
                cmd.item_sel = SEL_ZERO;
              end else begin
                cmd.load  = 1'b0;
                state_nxt = S_LIST;
                idx_nxt   = '0;
              end
            end
          endcase
        end
      end
      default: begin
        if (out_free) begin
          cmd.load     = 1'b1;
          cmd.code     = CODE_LISTED;
          cmd.item_sel = SEL_CELL;
          cmd.last     = list_last;
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
    endcase
  end

  assign out_valid_nxt = cmd.load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign out_valid = out_valid_r;

endmodule

/* src/sorted_set_table.sv */
// A result is captured in the output register at the end of its accept cycle; a list's
//   values follow from the list state. Insert, delete and search: one request per cycle
//   while out_stall is low; cells compare and shift at once. List: the input is stalled
//   while the N values come from the cell read mux, one per cycle while out_stall is low.
// Reset (rst_n low, synchronous) empties the table and drops any pending result;
//   cell contents are not cleared and are never read beyond the stored count.
// ----------------------------------------------------------------------------
// sorted_set_table: bounded ascending set of distinct signed values
// A request inserts, deletes, searches for a value, or lists the whole set
// in ascending order. Controller and datapath are joined by command/status.
// ----------------------------------------------------------------------------
module sorted_set_table (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  ssts_pkg::kind_t   in_kind,
  input  ssts_pkg::value_t  in_value,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output ssts_pkg::code_t   out_code,
  output ssts_pkg::value_t  out_item_value,
  output logic              out_last
);
  import ssts_pkg::*;

  dp_cmd_t  cmd;    // per-cycle update and result-capture command
  dp_stat_t stat;   // match, full, empty and fill count of the cell row

  // Controller: accepts a request only when the output register is free or
  // draining this cycle, and stays busy while a list request walks the cells.
  ssts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: the cell row, the fill count and the result payload register.
  ssts_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_code       (out_code),
    .out_item_value (out_item_value),
    .out_last       (out_last)
  );

  // ---- assertions ----

  // fill count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // a request is taken only when the result register can take its result
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (!out_valid || !out_stall))
    else $error("request accepted while result register blocked");

  // an insert grows the table by exactly one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> stat.count == $past(stat.count) + CNT_W'(1))
    else $error("insert did not grow the table by one");

  // a delete shrinks the table by exactly one
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del |=> stat.count == $past(stat.count) - CNT_W'(1))
    else $error("delete did not shrink the table by one");

endmodule
